@@ hdl/ted_pkg.sv @@
package ted_pkg;

	localparam int ACCEL_W = 16;
	localparam int GAP_W   = 32;
	localparam int SPEED_W = 13;
	localparam int PCT_W   = 7;
	localparam int COUNT_W = 4;
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 32;

	// Register indexes on the configuration port.
	localparam logic [CFG_IDX_W-1:0] REG_IMPACT_THRESHOLD = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_PULSE_TIMEOUT    = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_DROP_PERCENT     = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_MIN_TARGET       = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_TIMEOUTS_NEEDED  = 3'd4;

	typedef enum logic [1:0] {
		METHOD_NONE    = 2'd0,
		METHOD_IMPACT  = 2'd1,
		METHOD_DROP    = 2'd2,
		METHOD_TIMEOUT = 2'd3
	} method_t;

	typedef struct packed {
		logic               mode;
		logic [ACCEL_W-1:0] accel_mg;
		logic [GAP_W-1:0]   pulse_gap_us;
		logic [SPEED_W-1:0] speed_mm_s;
		logic [SPEED_W-1:0] target_mm_s;
	} sample_word_t;

	typedef struct packed {
		method_t            end_method;
		logic [SPEED_W-1:0] mean_speed_mm_s;
	} result_word_t;

	// Controls shared by every cell of the speed chain.
	typedef struct packed {
		logic shift;
		logic clear;
	} ring_ctl_t;

endpackage

@@ hdl/ted_cell.sv @@
module ted_cell import ted_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  ring_ctl_t          ctl,
	input  logic [SPEED_W-1:0] prev,
	output logic [SPEED_W-1:0] value
);

	logic [SPEED_W-1:0] value_q;

	// A clear wins over a shift; otherwise the cell takes its neighbor's entry.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			value_q <= '0;
		end else if (ctl.clear) begin
			value_q <= '0;
		end else if (ctl.shift) begin
			value_q <= prev;
		end
	end

	assign value = value_q;

endmodule

@@ hdl/travel_end_detector_unit.sv @@
// A sample word passes through stage 1, stage 2 and the output register before result_valid rises.
// Throughput: one sample word per cycle while sample_stall is low; the running sum and late counter are registered.
// Stalls on the result side back up through three registered stages before sample_stall rises.
// Reset (arst_n low, asynchronous): speed chain, running sum, late count and all valid bits
// clear at once, and the configuration registers return to their documented defaults.
module travel_end_detector_unit import ted_pkg::*; #(
	parameter int RING_DEPTH = 5
) (
	input  logic                  clk,
	input  logic                  arst_n,

	input  logic                  sample_valid,
	output logic                  sample_stall,
	input  sample_word_t          sample,

	output logic                  result_valid,
	input  logic                  result_stall,
	output result_word_t          result,

	input  logic                  cfg_valid,
	output logic                  cfg_ready,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data
);

	// The ring holds the last RING_DEPTH speeds. Only their sum matters for the checks and
	// the mean, so the ring is built as a chain of cells: each written speed enters the first
	// cell and the oldest falls out of the last one, which keeps the same set of entries as a
	// ring with a write pointer and needs no slot register.
	localparam int LOG_D = (RING_DEPTH > 1) ? $clog2(RING_DEPTH) : 1;
	localparam int SUM_W = SPEED_W + LOG_D;
	// The threshold target * drop_percent * depth and the scaled sum * 100 share this width.
	localparam int CMP_W = SPEED_W + PCT_W + LOG_D;

	// The mean is sum / RING_DEPTH, done as a multiply by a rounded-up reciprocal. With a
	// shift of SUM_W + LOG_D the quotient is exact for every sum that fits in SUM_W bits.
	localparam int SHIFT  = SUM_W + LOG_D;
	localparam int RCP_W  = SHIFT + 1;
	localparam int PROD_W = SUM_W + RCP_W;
	localparam longint unsigned RECIP_L =
		((longint'(1) << SHIFT) + longint'(RING_DEPTH) - 1) / longint'(RING_DEPTH);
	localparam logic [RCP_W-1:0] RECIP = RCP_W'(RECIP_L);
	localparam logic [CMP_W-1:0] PCT_SCALE = CMP_W'(100);
	localparam logic [CMP_W-1:0] DEPTH_C   = CMP_W'(RING_DEPTH);
	localparam logic [COUNT_W-1:0] LATE_MAX = '1;

	// Configuration registers. The user must write them only while the block is idle; the block does not enforce this.
	logic [ACCEL_W-1:0] impact_thr_q;
	logic [GAP_W-1:0]   pulse_timeout_q;
	logic [PCT_W-1:0]   drop_pct_q;
	logic [SPEED_W-1:0] min_target_q;
	logic [COUNT_W-1:0] needed_q;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			impact_thr_q    <= ACCEL_W'(2000);
			pulse_timeout_q <= GAP_W'(2000000);
			drop_pct_q      <= PCT_W'(50);
			min_target_q    <= SPEED_W'(200);
			needed_q        <= COUNT_W'(3);
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				REG_IMPACT_THRESHOLD: impact_thr_q    <= cfg_data[ACCEL_W-1:0];
				REG_PULSE_TIMEOUT:    pulse_timeout_q <= cfg_data[GAP_W-1:0];
				REG_DROP_PERCENT:     drop_pct_q      <= cfg_data[PCT_W-1:0];
				REG_MIN_TARGET:       min_target_q    <= cfg_data[SPEED_W-1:0];
				REG_TIMEOUTS_NEEDED:  needed_q        <= cfg_data[COUNT_W-1:0];
				default: ;
			endcase
		end
	end

	// Flow control. Each stage loads when it is empty or when the one after it moves on.
	logic v_s1, v_s2, v_q;
	logic ready_out, adv2, adv1, take, fire;

	assign ready_out    = !v_q || !result_stall;
	assign adv2         = !v_s2 || ready_out;
	assign adv1         = !v_s1 || adv2;
	assign sample_stall = !adv1;
	assign take         = sample_valid && adv1;
	assign fire         = v_s1 && adv2;

	// Stage 1: the compares that need no state, and the drop threshold product.
	logic               mode_s1;
	logic               impact_s1;
	logic               late_s1;
	logic               tgt_ok_s1;
	logic [SPEED_W-1:0] speed_s1;
	logic [CMP_W-1:0]   thr_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (adv1) begin
			v_s1 <= sample_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			mode_s1   <= sample.mode;
			impact_s1 <= sample.accel_mg > impact_thr_q;
			late_s1   <= sample.pulse_gap_us > pulse_timeout_q;
			tgt_ok_s1 <= sample.target_mm_s > min_target_q;
			speed_s1  <= sample.speed_mm_s;
			thr_s1    <= CMP_W'(sample.target_mm_s) * CMP_W'(drop_pct_q) * DEPTH_C;
		end
	end

	// Speed chain and the running sum of its entries.
	ring_ctl_t          ring_ctl;
	logic [SPEED_W-1:0] cell_val [RING_DEPTH];

	for (genvar i = 0; i < RING_DEPTH; i++) begin : g_cell
		ted_cell u_cell (
			.clk    (clk),
			.arst_n (arst_n),
			.ctl    (ring_ctl),
			.prev   ((i == 0) ? speed_s1 : cell_val[(i == 0) ? 0 : i - 1]),
			.value  (cell_val[i])
		);
	end

	logic [SUM_W-1:0]   sum_q;
	logic [COUNT_W-1:0] late_q;

	// Stage 2 decision. A mode word clears the chain, the sum and the late count. The impact
	// check leaves the chain alone; otherwise the sample enters the chain and the sum after
	// that write feeds the drop check. The late count moves only when neither check fires.
	logic [SUM_W-1:0]   sum_new;
	logic [CMP_W-1:0]   sum_scaled;
	logic               drop_hit;
	logic [COUNT_W-1:0] late_inc;
	logic [SUM_W-1:0]   sum_next;
	logic [COUNT_W-1:0] late_next;
	method_t            method;

	always_comb begin
		sum_new    = sum_q - SUM_W'(cell_val[RING_DEPTH-1]) + SUM_W'(speed_s1);
		sum_scaled = CMP_W'(sum_new) * PCT_SCALE;
		drop_hit   = tgt_ok_s1 && (sum_scaled < thr_s1);
		late_inc   = (late_q == LATE_MAX) ? late_q : late_q + COUNT_W'(1);

		ring_ctl  = '0;
		sum_next  = sum_q;
		late_next = late_q;
		method    = METHOD_NONE;

		if (fire) begin
			if (mode_s1) begin
				ring_ctl.clear = 1'b1;
				sum_next       = '0;
				late_next      = '0;
			end else if (impact_s1) begin
				method = METHOD_IMPACT;
			end else begin
				ring_ctl.shift = 1'b1;
				sum_next       = sum_new;
				if (drop_hit) begin
					method = METHOD_DROP;
				end else if (late_s1) begin
					if (late_inc >= needed_q) begin
						late_next = '0;
						method    = METHOD_TIMEOUT;
					end else begin
						late_next = late_inc;
					end
				end else begin
					late_next = '0;
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sum_q  <= '0;
			late_q <= '0;
		end else begin
			sum_q  <= sum_next;
			late_q <= late_next;
		end
	end

	// Stage 2 register: the method and the ring sum after this word.
	method_t          method_s2;
	logic [SUM_W-1:0] sum_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2 <= 1'b0;
		end else if (adv2) begin
			v_s2 <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (fire) begin
			method_s2 <= method;
			sum_s2    <= sum_next;
		end
	end

	// Output register: the mean comes from the reciprocal multiply on the stored sum.
	logic [PROD_W-1:0] mean_prod;
	result_word_t      result_q;

	assign mean_prod = PROD_W'(sum_s2) * PROD_W'(RECIP);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_q <= 1'b0;
		end else if (ready_out) begin
			v_q <= v_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (ready_out && v_s2) begin
			result_q.end_method      <= method_s2;
			result_q.mean_speed_mm_s <= mean_prod[SHIFT +: SPEED_W];
		end
	end

	assign result_valid = v_q;
	assign result       = result_q;

endmodule

@@ hdl/ted_checker.sv @@
module ted_checker import ted_pkg::*; (
	input logic                  clk,
	input logic                  arst_n,
	input logic                  sample_valid,
	input logic                  sample_stall,
	input logic                  result_valid,
	input logic                  result_stall,
	input result_word_t          result
);

	// Words accepted but not yet delivered; the pipeline holds at most three.
	logic [2:0] pending_q;
	logic       in_acc, out_acc;

	assign in_acc  = sample_valid && !sample_stall;
	assign out_acc = result_valid && !result_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pending_q <= '0;
		end else if (in_acc && !out_acc) begin
			pending_q <= pending_q + 3'd1;
		end else if (out_acc && !in_acc) begin
			pending_q <= pending_q - 3'd1;
		end
	end

	a_result_holds: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && result_stall |=> result_valid && $stable(result))
		else $error("result word changed or dropped while stalled");

	a_stall_only_when_full: assert property (@(posedge clk) disable iff (!arst_n)
		sample_stall |-> result_valid && result_stall)
		else $error("sample side stalled while the result side can move");

	a_pending_bound: assert property (@(posedge clk) disable iff (!arst_n)
		pending_q <= 3'd3)
		else $error("more words in flight than the pipeline holds");

	a_no_invented_result: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid |-> pending_q != 3'd0)
		else $error("result word shown with no sample word in flight");

endmodule

bind travel_end_detector_unit ted_checker u_ted_checker (.*);
